>>> rtl/core/tile_background_pixel_renderer_unit_macros.svh
// Assertion macros for the tile background pixel renderer
`ifndef TILE_BACKGROUND_PIXEL_RENDERER_UNIT_MACROS_SVH
`define TILE_BACKGROUND_PIXEL_RENDERER_UNIT_MACROS_SVH
`ifndef SYNTHESIS
// antecedent implies consequent in the same cycle
`define TBPR_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tbpr assertion failed");
// antecedent implies consequent in the next cycle
`define TBPR_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tbpr assertion failed");
`else
`define TBPR_ASSERT_IMPL(lbl, clk, rst, ante, cons)
`define TBPR_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

>>> rtl/core/tbpr_pkg.sv
// Shared types and constants of the tile background pixel renderer
`default_nettype none
package tbpr_pkg;
   localparam int VRAM_BYTES    = 8192;
   localparam int VRAM_ADDR_W   = $clog2(VRAM_BYTES);
   localparam int WORD_ADDR_W   = VRAM_ADDR_W - 1;
   localparam int VISIBLE_LINES = 144;

   localparam logic ACT_WRITE  = 1'b0;
   localparam logic ACT_RENDER = 1'b1;

   localparam int CSR_INDEX_W = 3;
   localparam logic [CSR_INDEX_W-1:0] CSR_SCROLL_X   = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SCROLL_Y   = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_BKGD_ON    = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAP_SEL    = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_TILE_SEL   = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_PALETTE    = 3'd5;

   // map base 0x1800 / 0x1C00: top two address bits set, next bit is map select
   localparam logic [1:0] MAP_BASE_TOP = 2'b11;

   typedef struct packed {
      logic [7:0] scroll_x;
      logic [7:0] scroll_y;
      logic       bkgd_on;
      logic       map_sel;
      logic       tile_sel;
      logic [7:0] palette;
   } cfg_type;

   typedef struct packed {
      logic                   wr_en;
      logic [VRAM_ADDR_W-1:0] wr_addr;
      logic [7:0]             wr_data;
      logic                   rd_en;
      logic [WORD_ADDR_W-1:0] rd_addr;
   } vram_req_type;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_MAP  = 3'b010,
      ST_ROW  = 3'b100
   } state_type;
endpackage
`default_nettype wire

>>> rtl/core/tbpr_csr.sv
// Configuration register file of the renderer
`default_nettype none
module tbpr_csr (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             csr_valid,
   output logic                                  csr_ready,
   input  wire logic [tbpr_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [7:0]                       csr_data,
   output tbpr_pkg::cfg_type                     cfg
);
   import tbpr_pkg::*;

   cfg_type cfg_ff, cfg_in;

   assign csr_ready = 1'b1;
   assign cfg = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_SCROLL_X:  cfg_in.scroll_x  = csr_data;
            CSR_SCROLL_Y:  cfg_in.scroll_y  = csr_data;
            CSR_BKGD_ON:   cfg_in.bkgd_on   = csr_data[0];
            CSR_MAP_SEL:   cfg_in.map_sel   = csr_data[0];
            CSR_TILE_SEL:  cfg_in.tile_sel  = csr_data[0];
            CSR_PALETTE:   cfg_in.palette   = csr_data;
            default:       cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.scroll_x  <= 8'd0;
         cfg_ff.scroll_y  <= 8'd0;
         cfg_ff.bkgd_on   <= 1'b1;
         cfg_ff.map_sel   <= 1'b0;
         cfg_ff.tile_sel  <= 1'b1;
         cfg_ff.palette   <= 8'd252;
      end else begin
         cfg_ff <= cfg_in;
      end
   end
endmodule
`default_nettype wire

>>> rtl/core/tbpr_vram.sv
// Video memory: two byte banks (even and odd addresses), one registered read
`default_nettype none
module tbpr_vram (
   input  wire logic                   clock,
   input  wire tbpr_pkg::vram_req_type req,
   output logic [7:0]                  rd_even,
   output logic [7:0]                  rd_odd
);
   import tbpr_pkg::*;

   localparam int BANK_WORDS = VRAM_BYTES / 2;

   logic [7:0] even_mem_ff [BANK_WORDS];
   logic [7:0] odd_mem_ff  [BANK_WORDS];
   logic [7:0] rd_even_ff, rd_odd_ff;

   assign rd_even = rd_even_ff;
   assign rd_odd  = rd_odd_ff;

   always_ff @(posedge clock) begin
      if (req.wr_en && !req.wr_addr[0]) begin
         even_mem_ff[req.wr_addr[VRAM_ADDR_W-1:1]] <= req.wr_data;
      end
      if (req.rd_en) begin
         rd_even_ff <= even_mem_ff[req.rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (req.wr_en && req.wr_addr[0]) begin
         odd_mem_ff[req.wr_addr[VRAM_ADDR_W-1:1]] <= req.wr_data;
      end
      if (req.rd_en) begin
         rd_odd_ff <= odd_mem_ff[req.rd_addr];
      end
   end
endmodule
`default_nettype wire

>>> rtl/core/tile_background_pixel_renderer_unit.sv
// A render transaction does a map read, then a 16-bit tile row read on the same
// banked video memory port; a new request is taken in the row step once the result
// slot is free. One memory write transaction per cycle while req_tready is high.
// Reset: synchronous, active high; clears the sequencer and the result valid and
// loads the configuration defaults. Video memory contents are not cleared and are
// undefined until written.
`default_nettype none
`include "tile_background_pixel_renderer_unit_macros.svh"
module tile_background_pixel_renderer_unit #(
   parameter int SCREEN_WIDTH = 160
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   // request: tuser = action (0 write byte, 1 render pixel)
   input  wire logic                             req_tvalid,
   output logic                                  req_tready,
   // req_tdata from bit 0: mem_address[12:0], mem_byte[7:0],
   // screen_line[7:0], screen_column[7:0], 3 zero bits
   input  wire logic [39:0]                      req_tdata,
   input  wire logic                             req_tuser,
   // response
   output logic                                  rsp_tvalid,
   input  wire logic                             rsp_tready,
   // rsp_tdata from bit 0: shade[1:0], out_line[7:0], out_column[7:0], 6 zero bits
   output logic [23:0]                           rsp_tdata,
   // rsp_tuser = drawn
   output logic                                  rsp_tuser,
   // configuration write channel
   input  wire logic                             csr_valid,
   output logic                                  csr_ready,
   input  wire logic [tbpr_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [7:0]                       csr_data
);
   import tbpr_pkg::*;

   cfg_type      cfg;
   vram_req_type vram_req;
   logic [7:0]   rd_even, rd_odd;

   tbpr_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   tbpr_vram u_vram (
      .clock   (clock),
      .req     (vram_req),
      .rd_even (rd_even),
      .rd_odd  (rd_odd)
   );

   // request fields
   logic [VRAM_ADDR_W-1:0] in_addr;
   logic [7:0]             in_byte, in_line, in_column;
   assign in_addr   = req_tdata[12:0];
   assign in_byte   = req_tdata[20:13];
   assign in_line   = req_tdata[28:21];
   assign in_column = req_tdata[36:29];

   state_type state_ff, state_in;
   logic [7:0] line_ff, column_ff, px_ff, py_ff;
   logic       rsp_valid_ff;
   logic [23:0] rsp_data_ff;
   logic       rsp_drawn_ff;

   logic accept, render_acc, out_free, load_out;
   logic [7:0] px_in, py_in;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE) || ((state_ff == ST_ROW) && out_free);
   assign accept     = req_tvalid && req_tready;
   assign render_acc = accept && (req_tuser == ACT_RENDER);
   assign load_out   = (state_ff == ST_ROW) && out_free;

   // scrolled background coordinates, wrap at 256
   assign px_in = in_column + cfg.scroll_x;
   assign py_in = in_line + cfg.scroll_y;

   // map entry address {11, map_sel, py[7:3], px[7:3]}; byte lane is px[3]
   logic [VRAM_ADDR_W-1:0] map_addr;
   assign map_addr = {MAP_BASE_TOP, cfg.map_sel, py_in[7:3], px_in[7:3]};

   // tile row word: signed mode puts index 0..127 at 0x1000 and 128..255 at 0x0800
   logic [7:0]             tile_idx;
   logic                   tile_top;
   logic [WORD_ADDR_W-1:0] row_word;
   assign tile_idx = px_ff[3] ? rd_odd : rd_even;
   assign tile_top = !cfg.tile_sel && !tile_idx[7];
   assign row_word = {tile_top, tile_idx, py_ff[2:0]};

   always_comb begin
      vram_req.wr_en   = accept && (req_tuser == ACT_WRITE);
      vram_req.wr_addr = in_addr;
      vram_req.wr_data = in_byte;
      vram_req.rd_en   = render_acc || (state_ff == ST_MAP);
      vram_req.rd_addr = (state_ff == ST_MAP) ? row_word : map_addr[VRAM_ADDR_W-1:1];
   end

   // pixel from the two bit planes, leftmost pixel in bit 7
   logic [2:0] bit_sel;
   logic [1:0] pix_color, shade_raw;
   logic       on_screen, drawn;
   assign bit_sel   = ~px_ff[2:0];
   assign pix_color = {rd_odd[bit_sel], rd_even[bit_sel]};
   assign shade_raw = 2'(cfg.palette >> {pix_color, 1'b0});
   assign on_screen = (line_ff < 8'(VISIBLE_LINES))
                   && ({1'b0, column_ff} < 9'(SCREEN_WIDTH));
   assign drawn     = cfg.bkgd_on && on_screen;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (render_acc) state_in = ST_MAP;
         ST_MAP:  state_in = ST_ROW;
         ST_ROW: begin
            // row data stays in the bank registers until the result slot frees
            if (out_free) state_in = render_acc ? ST_MAP : ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (load_out)        rsp_valid_ff <= 1'b1;
         else if (rsp_tready) rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (render_acc) begin
         line_ff   <= in_line;
         column_ff <= in_column;
         px_ff     <= px_in;
         py_ff     <= py_in;
      end
      if (load_out) begin
         rsp_data_ff  <= {6'd0, column_ff, line_ff, drawn ? shade_raw : 2'd0};
         rsp_drawn_ff <= drawn;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_drawn_ff;

   `TBPR_ASSERT_NEXT(a_map_to_row, clock, reset, state_ff == ST_MAP, state_ff == ST_ROW)
   `TBPR_ASSERT_NEXT(a_render_starts, clock, reset, render_acc, state_ff == ST_MAP)
   `TBPR_ASSERT_IMPL(a_no_accept_in_map, clock, reset, state_ff == ST_MAP, !req_tready)
   `TBPR_ASSERT_IMPL(a_undrawn_zero, clock, reset, rsp_tvalid && !rsp_tuser,
                     rsp_tdata[1:0] == 2'd0)
   `TBPR_ASSERT_NEXT(a_result_follows, clock, reset, load_out, rsp_tvalid)
endmodule
`default_nettype wire
